// ----- rtl/core/sprite_alpha_blit_rgb565_unit_macros.svh -----
// assertion macros used by the checker file
`ifndef SPRITE_ALPHA_BLIT_RGB565_UNIT_MACROS_SVH
`define SPRITE_ALPHA_BLIT_RGB565_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SAB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sab check failed");

// next-cycle implication, disabled while reset is held
`define SAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sab check failed");

`endif

// ----- rtl/core/sab_pkg.sv -----
// shared constants and payload types of the sprite alpha blitter
package sab_pkg;

    localparam int SCREEN_W   = 320;
    localparam int SCREEN_H   = 240;
    localparam int SPRITE_DIM = 64;
    localparam int FB_WORDS   = SCREEN_W * SCREEN_H;

    // address field width is fixed by the bus
    localparam int FB_AW   = 17;
    localparam int CNT_W   = $clog2(SPRITE_DIM);
    localparam int XY_W    = 11;
    localparam int COORD_W = 13;
    localparam int CFG_W   = 12;
    localparam int CFG_IW  = 1;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_BLEND = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_SPRITE_X = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_SPRITE_Y = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [16:0] address;
        logic [15:0] write_pixel;
        logic [31:0] sprite_pixel;
    } t_in_item;

    typedef struct packed {
        logic [15:0] read_pixel;
        logic        pixel_written;
        logic        sprite_done;
    } t_out_item;

endpackage

// ----- rtl/core/sprite_alpha_blit_rgb565_unit.sv -----
// top level: rgb565 framebuffer with an alpha-blending sprite blitter
//
//  channel   direction  handshake               payload
//  command   in         start, busy             i_item (t_in_item)
//  result    out        o_strobe (one cycle)    o_result (t_out_item)
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  write and unused actions: strobe follows the transfer through the address and read states
//  read and blend actions: strobe follows the transfer through the address
//  stage, the registered framebuffer read and the write stage (blend write-back)
//  a new command is taken in the cycle its predecessor's strobe is shown
//  after reset a clearing pass zeroes all 76800 framebuffer words, one
//  word a cycle, with busy high; config writes are taken throughout
//  the receiver cannot stall, results are never held back
module sprite_alpha_blit_rgb565_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  sab_pkg::t_in_item              i_item,
    // result channel
    output logic                           o_strobe,
    output sab_pkg::t_out_item             o_result,
    // config channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sab_pkg::CFG_IW-1:0]     i_cfg_index,
    input  logic [sab_pkg::CFG_W-1:0]      i_cfg_data
);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;

    localparam int FB_AW   = sab_pkg::FB_AW;
    localparam int CNT_W   = sab_pkg::CNT_W;
    localparam int COORD_W = sab_pkg::COORD_W;
    localparam int XY_W    = sab_pkg::XY_W;
    localparam int CFG_W   = sab_pkg::CFG_W;

    // framebuffer
    logic [15:0] r_mem [sab_pkg::FB_WORDS];
    logic [15:0] r_rdata;

    // control state
    logic [2:0]         r_state, n_state;
    logic [FB_AW-1:0]   r_clr_cnt, n_clr_cnt;
    logic [CNT_W-1:0]   r_col, n_col;
    logic [CNT_W-1:0]   r_row, n_row;
    logic [CFG_W-1:0]   r_sprite_x, n_sprite_x;
    logic [CFG_W-1:0]   r_sprite_y, n_sprite_y;
    logic               r_strobe, n_strobe;

    // item payload
    logic [1:0]         r_act, n_act;
    logic [FB_AW-1:0]   r_addr, n_addr;
    logic [15:0]        r_wpix, n_wpix;
    logic [31:0]        r_spix, n_spix;
    logic [COORD_W-1:0] r_sx, n_sx;
    logic [COORD_W-1:0] r_sy, n_sy;
    logic               r_hit, n_hit;
    logic               r_last, n_last;
    sab_pkg::t_out_item r_result, n_result;

    // memory port controls
    logic               mem_we;
    logic [FB_AW-1:0]   mem_waddr;
    logic [15:0]        mem_wdata;
    logic               mem_re;

    logic               accept;
    logic               col_end;
    logic               row_end;
    logic [15:0]        blended;

    sab_blend u_blend (
        .i_sprite_pixel (r_spix),
        .i_dest         (r_rdata),
        .o_pixel        (blended)
    );

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

    assign col_end = (r_col == CNT_W'(sab_pkg::SPRITE_DIM - 1));
    assign row_end = (r_row == CNT_W'(sab_pkg::SPRITE_DIM - 1));

    always_comb begin
        n_state    = r_state;
        n_clr_cnt  = r_clr_cnt;
        n_col      = r_col;
        n_row      = r_row;
        n_sprite_x = r_sprite_x;
        n_sprite_y = r_sprite_y;
        n_strobe   = 1'b0;
        n_act      = r_act;
        n_addr     = r_addr;
        n_wpix     = r_wpix;
        n_spix     = r_spix;
        n_sx       = r_sx;
        n_sy       = r_sy;
        n_hit      = r_hit;
        n_last     = r_last;
        n_result   = r_result;
        mem_we     = 1'b0;
        mem_waddr  = r_addr;
        mem_wdata  = r_wpix;
        mem_re     = 1'b0;

        // config transfer: the user must issue it only while idle; the block does not enforce this
        if (i_cfg_valid) begin
            case (i_cfg_index)
                sab_pkg::CFG_SPRITE_X: n_sprite_x = i_cfg_data;
                sab_pkg::CFG_SPRITE_Y: n_sprite_y = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                // zero one word a cycle
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt;
                mem_wdata = 16'h0000;
                n_clr_cnt = r_clr_cnt + FB_AW'(1);
                if (r_clr_cnt == FB_AW'(sab_pkg::FB_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_act  = i_item.action;
                    n_addr = i_item.address;
                    n_wpix = i_item.write_pixel;
                    n_spix = i_item.sprite_pixel;
                    // screen position of this sprite pixel
                    n_sx = {{(COORD_W-CFG_W){r_sprite_x[CFG_W-1]}}, r_sprite_x}
                           + COORD_W'(r_col);
                    n_sy = {{(COORD_W-CFG_W){r_sprite_y[CFG_W-1]}}, r_sprite_y}
                           + COORD_W'(r_row);
                    n_last = 1'b0;
                    if (i_item.action == sab_pkg::ACT_BLEND) begin
                        // raster walk through the sprite, wrap after the last pixel
                        if (col_end) begin
                            n_col = '0;
                            if (row_end) begin
                                n_row  = '0;
                                n_last = 1'b1;
                            end else begin
                                n_row = r_row + CNT_W'(1);
                            end
                        end else begin
                            n_col = r_col + CNT_W'(1);
                        end
                    end
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                case (r_act)
                    sab_pkg::ACT_BLEND: begin
                        n_hit = !r_sx[COORD_W-1] && (r_sx < COORD_W'(sab_pkg::SCREEN_W))
                             && !r_sy[COORD_W-1] && (r_sy < COORD_W'(sab_pkg::SCREEN_H));
                        n_addr = FB_AW'(r_sy[XY_W-1:0]) * FB_AW'(sab_pkg::SCREEN_W)
                               + FB_AW'(r_sx[XY_W-1:0]);
                    end
                    sab_pkg::ACT_WRITE,
                    sab_pkg::ACT_READ: begin
                        n_hit = (r_addr < FB_AW'(sab_pkg::FB_WORDS));
                    end
                    default: begin
                        n_hit = 1'b0;
                    end
                endcase
                n_state = S_READ;
            end
            S_READ: begin
                n_result = '0;
                case (r_act)
                    sab_pkg::ACT_WRITE: begin
                        mem_we   = r_hit;
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                    sab_pkg::ACT_READ,
                    sab_pkg::ACT_BLEND: begin
                        mem_re  = r_hit;
                        n_state = S_WRITE;
                    end
                    default: begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                endcase
            end
            S_WRITE: begin
                n_result = '0;
                if (r_act == sab_pkg::ACT_READ) begin
                    n_result.read_pixel = r_hit ? r_rdata : 16'h0000;
                end else begin
                    // blend write-back of the word read last cycle
                    mem_we    = r_hit;
                    mem_wdata = blended;
                    n_result.pixel_written = r_hit;
                    n_result.sprite_done   = r_last;
                end
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_cnt  <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_sprite_x <= '0;
            r_sprite_y <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_cnt  <= n_clr_cnt;
            r_col      <= n_col;
            r_row      <= n_row;
            r_sprite_x <= n_sprite_x;
            r_sprite_y <= n_sprite_y;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_addr   <= n_addr;
        r_wpix   <= n_wpix;
        r_spix   <= n_spix;
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_hit    <= n_hit;
        r_last   <= n_last;
        r_result <= n_result;
    end

    // framebuffer ports: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[r_addr];
        end
    end

endmodule

// ----- rtl/core/sab_blend.sv -----
// per-channel alpha blend of a bgra8888 sprite pixel (alpha in the low byte) over an rgb565 word
module sab_blend (
    input  logic [31:0] i_sprite_pixel,
    input  logic [15:0] i_dest,
    output logic [15:0] o_pixel
);

    // dest + floor(alpha * (src - dest) / 256), low bits kept
    function automatic logic [5:0] blend_chan(
        input logic [5:0] src,
        input logic [5:0] dst,
        input logic [7:0] alpha
    );
        logic signed [6:0]  diff;
        logic signed [15:0] prod;
        logic signed [15:0] sum;
        diff = $signed({1'b0, src}) - $signed({1'b0, dst});
        prod = 16'($signed({1'b0, alpha})) * 16'(diff);
        sum  = $signed({10'b0, dst}) + (prod >>> 8);
        return sum[5:0];
    endfunction

    logic [7:0] alpha;
    logic [5:0] red;
    logic [5:0] green;
    logic [5:0] blue;

    assign alpha = i_sprite_pixel[7:0];

    assign red   = blend_chan({1'b0, i_sprite_pixel[15:11]}, {1'b0, i_dest[15:11]}, alpha);
    assign green = blend_chan(i_sprite_pixel[23:18], i_dest[10:5], alpha);
    assign blue  = blend_chan({1'b0, i_sprite_pixel[31:27]}, {1'b0, i_dest[4:0]}, alpha);

    assign o_pixel = {red[4:0], green, blue[4:0]};

endmodule

// ----- rtl/core/sab_checker.sv -----
// port-level checks on the sprite alpha blitter, bound to the top level
`include "sprite_alpha_blit_rgb565_unit_macros.svh"

module sab_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_strobe,
    input sab_pkg::t_out_item o_result
);

    // an accepted command occupies the block
    `SAB_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // no result in the cycle right after a transfer
    `SAB_ASSERT_NEXT(a_accept_no_strobe, i_clk, i_rst_n, start && !busy, !o_strobe)

    // a result is shown only when the block is free again
    `SAB_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)

    // a blend result never carries read data
    `SAB_ASSERT_NOW(a_written_no_read, i_clk, i_rst_n,
        o_strobe && o_result.pixel_written, o_result.read_pixel == 16'h0000)

endmodule

bind sprite_alpha_blit_rgb565_unit sab_checker u_sab_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
